// ===== design/ptp_od_pkg.sv =====
package ptp_od_pkg;

    // Event codes carried in the func field
    localparam logic [2:0] FUNC_SET_M2S  = 3'd0;
    localparam logic [2:0] FUNC_SET_S2M  = 3'd1;
    localparam logic [2:0] FUNC_SET_PEER = 3'd2;
    localparam logic [2:0] FUNC_CLR_M2S  = 3'd3;
    localparam logic [2:0] FUNC_CLR_S2M  = 3'd4;
    localparam logic [2:0] FUNC_CLR_PEER = 3'd5;

    // Command word: one timestamp event
    typedef struct packed {
        logic [2:0]         func;
        logic [63:0]        first_tx;
        logic [63:0]        first_rx;
        logic [63:0]        second_tx;
        logic [63:0]        second_rx;
        logic signed [63:0] corr_field;
    } cmd_word_t;

    // Result word: delay and offset snapshot
    typedef struct packed {
        logic               complete;
        logic signed [63:0] mean_delay;
        logic signed [63:0] master_offset;
        logic [63:0]        protocol_time;
    } res_word_t;

    // Event reduced to its net transit time
    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] net;
        logic [63:0] rx_time;
    } net_item_t;

    // Tracker outcome handed to the output stage
    typedef struct packed {
        logic        update;
        logic        done;
        logic [63:0] sum;
        logic [63:0] m2s_net;
        logic [63:0] rx_time;
        logic        m2s_ok;
        logic        s2m_ok;
        logic        peer_ok;
    } track_res_t;

endpackage

// ===== design/ptp_od_track.sv =====
module ptp_od_track (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  ptp_od_pkg::net_item_t   item,
    output ptp_od_pkg::track_res_t  trk
);
    import ptp_od_pkg::*;

    logic        m2s_ok_reg, m2s_ok_next;
    logic        s2m_ok_reg, s2m_ok_next;
    logic        peer_ok_reg, peer_ok_next;
    logic [63:0] m2s_net_reg, m2s_net_next;
    logic [63:0] s2m_net_reg, s2m_net_next;
    logic [63:0] peer_net_reg, peer_net_next;
    logic        done_reg, done_next;
    logic [63:0] rx_reg, rx_next;
    logic        is_set;
    logic        e2e_mode;
    logic        peer_mode;

    // Next state for the event in hand
    always_comb
    begin
        m2s_ok_next   = m2s_ok_reg;
        s2m_ok_next   = s2m_ok_reg;
        peer_ok_next  = peer_ok_reg;
        m2s_net_next  = m2s_net_reg;
        s2m_net_next  = s2m_net_reg;
        peer_net_next = peer_net_reg;
        done_next     = done_reg;
        rx_next       = rx_reg;
        is_set        = 1'b0;
        case (item.func)
            FUNC_SET_M2S:
            begin
                m2s_ok_next  = 1'b1;
                m2s_net_next = item.net;
                rx_next      = item.rx_time;
                is_set       = 1'b1;
            end
            FUNC_SET_S2M:
            begin
                peer_ok_next = 1'b0;
                s2m_ok_next  = 1'b1;
                s2m_net_next = item.net;
                rx_next      = item.rx_time;
                is_set       = 1'b1;
            end
            FUNC_SET_PEER:
            begin
                s2m_ok_next   = 1'b0;
                peer_ok_next  = 1'b1;
                peer_net_next = item.net;
                rx_next       = item.rx_time;
                is_set        = 1'b1;
            end
            FUNC_CLR_M2S:
            begin
                m2s_ok_next = 1'b0;
                done_next   = 1'b0;
            end
            FUNC_CLR_S2M:
            begin
                s2m_ok_next = 1'b0;
                done_next   = 1'b0;
            end
            FUNC_CLR_PEER:
            begin
                peer_ok_next = 1'b0;
                done_next    = 1'b0;
            end
            default:
            begin
                is_set = 1'b0;
            end
        endcase

        // Mode select; end-to-end wins over peer
        e2e_mode  = m2s_ok_next && s2m_ok_next;
        peer_mode = m2s_ok_next && peer_ok_next;
        if (is_set)
        begin
            done_next = e2e_mode || peer_mode;
        end
    end

    // Delay numerator before halving
    assign trk.update  = is_set && (e2e_mode || peer_mode);
    assign trk.done    = done_next;
    assign trk.sum     = e2e_mode ? (m2s_net_next + s2m_net_next) : peer_net_next;
    assign trk.m2s_net = m2s_net_next;
    assign trk.rx_time = rx_next;
    assign trk.m2s_ok  = m2s_ok_next;
    assign trk.s2m_ok  = s2m_ok_next;
    assign trk.peer_ok = peer_ok_next;

    // Commit when the event moves to the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2s_ok_reg   <= 1'b0;
            s2m_ok_reg   <= 1'b0;
            peer_ok_reg  <= 1'b0;
            m2s_net_reg  <= '0;
            s2m_net_reg  <= '0;
            peer_net_reg <= '0;
            done_reg     <= 1'b0;
            rx_reg       <= '0;
        end
        else if (take)
        begin
            m2s_ok_reg   <= m2s_ok_next;
            s2m_ok_reg   <= s2m_ok_next;
            peer_ok_reg  <= peer_ok_next;
            m2s_net_reg  <= m2s_net_next;
            s2m_net_reg  <= s2m_net_next;
            peer_net_reg <= peer_net_next;
            done_reg     <= done_next;
            rx_reg       <= rx_next;
        end
    end

endmodule

// ===== design/ptp_offset_delay_calc.sv =====
// PTP offset and mean path delay calculator.
// Command channel (cmd_valid / cmd_stall / cmd) carries one timestamp event
// per word: set or clear of the m2s, s2m or peer-delay set. Every command
// word produces exactly one result word on the result channel
// (res_valid / res_stall / res) with the complete flag, the stored mean
// delay, the stored offset from master and the latest receive time.
// Each accepted command passes through the register stages below in order.
// Throughput: one command per cycle while not stalled; four register stages
// (input, net transit, state tracker, output) each hold one word.
// Stalls: a stalled result holds its word; earlier stages keep filling and
// cmd_stall rises only once every stage, the input stage too, is occupied.
// Reset: all timestamp sets invalid, delay, offset and protocol time zero,
// pipeline empty.
module ptp_offset_delay_calc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  ptp_od_pkg::cmd_word_t  cmd,
    output logic                   res_valid,
    input  logic                   res_stall,
    output ptp_od_pkg::res_word_t  res
);
    import ptp_od_pkg::*;

    // Stage ready chain
    logic r1, r2, r3, r4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Input stage
    logic [2:0]  s1_func_reg;
    logic [63:0] s1_d1_reg;
    logic [63:0] s1_d2_reg;
    logic [63:0] s1_corr_reg;
    logic [63:0] s1_frx_reg;
    logic [63:0] s1_srx_reg;

    // Net transit stage
    net_item_t   s2_reg;
    net_item_t   s2_next;

    // Tracker and output stage
    track_res_t  trk;
    res_word_t   res_reg;
    logic [63:0] half_sum;

    assign r4 = !v4_reg || !res_stall;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign cmd_stall = !r1;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= cmd_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (r4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Input register with the two raw transits
    always_ff @(posedge clk)
    begin
        if (cmd_valid && r1)
        begin
            s1_func_reg <= cmd.func;
            s1_d1_reg   <= cmd.first_rx - cmd.first_tx;
            s1_d2_reg   <= cmd.second_rx - cmd.second_tx;
            s1_corr_reg <= $unsigned(cmd.corr_field);
            s1_frx_reg  <= cmd.first_rx;
            s1_srx_reg  <= cmd.second_rx;
        end
    end

    // Net transit: peer sums both legs, others take one leg
    always_comb
    begin
        s2_next.func = s1_func_reg;
        if (s1_func_reg == FUNC_SET_PEER)
        begin
            s2_next.net     = s1_d1_reg + s1_d2_reg - s1_corr_reg;
            s2_next.rx_time = s1_srx_reg;
        end
        else
        begin
            s2_next.net     = s1_d1_reg - s1_corr_reg;
            s2_next.rx_time = s1_frx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && r2)
        begin
            s2_reg <= s2_next;
        end
    end

    net_item_t s3_reg;

    always_ff @(posedge clk)
    begin
        if (v2_reg && r3)
        begin
            s3_reg <= s2_reg;
        end
    end

    ptp_od_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (v3_reg && r4),
        .item  (s3_reg),
        .trk   (trk)
    );

    // Arithmetic halving, rounds toward minus infinity
    assign half_sum = {trk.sum[63], trk.sum[63:1]};

    // Output register; delay and offset hold when not refreshed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (v3_reg && r4)
        begin
            res_reg.complete      <= trk.done;
            res_reg.protocol_time <= trk.rx_time;
            if (trk.update)
            begin
                res_reg.mean_delay    <= $signed(half_sum);
                res_reg.master_offset <= $signed(trk.m2s_net - half_sum);
            end
        end
    end

    assign res_valid = v4_reg;
    assign res       = res_reg;

    // s2m and peer sets never valid together
    a_excl_modes: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !(trk.s2m_ok && trk.peer_ok))
        else $error("s2m and peer sets both valid");

    // A fresh result needs a valid m2s set
    a_done_needs_m2s: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && trk.done) |-> trk.m2s_ok)
        else $error("complete without m2s set");

    // Empty input stage never stalls the sender
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !cmd_stall)
        else $error("stall with empty input stage");

    // Refreshed offset plus delay gives back the m2s net transit
    a_offset_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && r4 && trk.update) |=>
            ($unsigned(res.master_offset) + $unsigned(res.mean_delay)
             == $past(trk.m2s_net)))
        else $error("offset and delay inconsistent");

endmodule

// ===== tb/sv/ptp_offset_delay_calc_tb.sv =====
module ptp_offset_delay_calc_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptp_od_pkg::*;

    // Codes the block ignores
    localparam logic [2:0]  FUNC_RSVD_6  = 3'd6;
    localparam logic [2:0]  FUNC_RSVD_7  = 3'd7;

    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          N_EVENTS     = 1900;
    localparam int          N_PHASES     = 4;
    localparam int          MAX_REPORTS  = 10;

    // Sender idle and receiver stall percentages, one entry per phase
    localparam int IDLE_BY_PHASE[N_PHASES]  = '{0, 66, 0, 14};
    localparam int STALL_BY_PHASE[N_PHASES] = '{0, 0, 66, 14};

    typedef struct {
        cmd_word_t  w;
        bit         typed;
        res_word_t  want;
    } stim_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    cmd_word_t  cmd       = '0;
    logic       cmd_stall;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_word_t  res;

    int idle_pct  = 0;
    int stall_pct = 0;

    // Expected delay/offset snapshots, oldest first
    res_word_t  snap_q[$];
    stim_row_t  dir_rows[$];

    int err_cnt    = 0;
    int n_set      = 0;
    int n_clear    = 0;
    int n_ignored  = 0;
    int n_checked  = 0;
    int n_complete = 0;

    // Shadow of the timestamp sets and the stored outputs
    bit                 m2s_valid  = 1'b0;
    bit                 s2m_valid  = 1'b0;
    bit                 peer_valid = 1'b0;
    bit                 fresh      = 1'b0;
    logic [63:0]        m2s_tx     = '0;
    logic [63:0]        m2s_rx     = '0;
    logic [63:0]        m2s_corr   = '0;
    logic [63:0]        s2m_tx     = '0;
    logic [63:0]        s2m_rx     = '0;
    logic [63:0]        s2m_corr   = '0;
    logic [63:0]        preq_tx    = '0;
    logic [63:0]        preq_rx    = '0;
    logic [63:0]        presp_tx   = '0;
    logic [63:0]        presp_rx   = '0;
    logic [63:0]        presp_corr = '0;
    logic signed [63:0] delay_q    = '0;
    logic signed [63:0] offset_q   = '0;
    logic [63:0]        last_rx    = '0;

    ptp_offset_delay_calc u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Apply one event to the shadow state and return the snapshot it yields
    function automatic res_word_t predict_offset_delay(cmd_word_t w);
        logic [63:0]        m2s_transit;
        logic signed [63:0] path_sum;
        bit                 is_set;
        bit                 have_mode;
        res_word_t          r;
        is_set    = 1'b0;
        have_mode = 1'b0;
        path_sum  = '0;
        case (w.func)
            FUNC_SET_M2S:
            begin
                last_rx   = w.first_rx;
                m2s_valid = 1'b1;
                m2s_tx    = w.first_tx;
                m2s_rx    = w.first_rx;
                m2s_corr  = w.corr_field;
                is_set    = 1'b1;
            end
            FUNC_SET_S2M:
            begin
                peer_valid = 1'b0;
                last_rx    = w.first_rx;
                s2m_valid  = 1'b1;
                s2m_tx     = w.first_tx;
                s2m_rx     = w.first_rx;
                s2m_corr   = w.corr_field;
                is_set     = 1'b1;
            end
            FUNC_SET_PEER:
            begin
                s2m_valid  = 1'b0;
                last_rx    = w.second_rx;
                peer_valid = 1'b1;
                preq_tx    = w.first_tx;
                preq_rx    = w.first_rx;
                presp_tx   = w.second_tx;
                presp_rx   = w.second_rx;
                presp_corr = w.corr_field;
                is_set     = 1'b1;
            end
            FUNC_CLR_M2S:
            begin
                m2s_valid = 1'b0;
                fresh     = 1'b0;
            end
            FUNC_CLR_S2M:
            begin
                s2m_valid = 1'b0;
                fresh     = 1'b0;
            end
            FUNC_CLR_PEER:
            begin
                peer_valid = 1'b0;
                fresh      = 1'b0;
            end
            default: ;
        endcase

        if (is_set)
        begin
            m2s_transit = m2s_rx - m2s_tx;
            // end-to-end takes priority over peer
            if (m2s_valid && s2m_valid)
            begin
                path_sum  = m2s_transit + (s2m_rx - s2m_tx) - s2m_corr - m2s_corr;
                have_mode = 1'b1;
            end
            else if (m2s_valid && peer_valid)
            begin
                path_sum  = (preq_rx - preq_tx) + (presp_rx - presp_tx) - presp_corr;
                have_mode = 1'b1;
            end
            if (have_mode)
            begin
                delay_q  = path_sum >>> 1;
                offset_q = m2s_transit - m2s_corr - delay_q;
                fresh    = 1'b1;
            end
            else
            begin
                fresh = 1'b0;
            end
        end

        r.complete      = fresh;
        r.mean_delay    = delay_q;
        r.master_offset = offset_q;
        r.protocol_time = last_rx;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] f, logic [63:0] ftx, logic [63:0] frx,
                                    logic [63:0] stx, logic [63:0] srx, logic [63:0] corr,
                                    bit typed = 1'b0, res_word_t want = '0);
        stim_row_t row;
        row.w.func       = f;
        row.w.first_tx   = ftx;
        row.w.first_rx   = frx;
        row.w.second_tx  = stx;
        row.w.second_rx  = srx;
        row.w.corr_field = corr;
        row.typed        = typed;
        row.want         = want;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receive stamp near the send stamp most of the time, sometimes anywhere
    function automatic logic [63:0] rand_rx(logic [63:0] tx);
        case ($urandom_range(3))
            0:       return rand64();
            1:       return tx - {32'd0, $urandom};
            default: return tx + {32'd0, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] rand_corr();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(3))
            0:       return rand64();
            1:       return '0;
            default: return {{32{s[31]}}, s};
        endcase
    endfunction

    // Mostly set events so both modes get exercised; some clears and noise
    function automatic cmd_word_t rand_event();
        cmd_word_t w;
        int        k;
        k            = $urandom_range(99);
        w.first_tx   = rand64();
        w.first_rx   = rand_rx(w.first_tx);
        w.second_tx  = rand64();
        w.second_rx  = rand_rx(w.second_tx);
        w.corr_field = rand_corr();
        if (k < 34)
            w.func = FUNC_SET_M2S;
        else if (k < 58)
            w.func = FUNC_SET_S2M;
        else if (k < 80)
            w.func = FUNC_SET_PEER;
        else if (k < 85)
            w.func = FUNC_CLR_M2S;
        else if (k < 90)
            w.func = FUNC_CLR_S2M;
        else if (k < 95)
            w.func = FUNC_CLR_PEER;
        else if (k < 98)
            w.func = FUNC_RSVD_6;
        else
            w.func = FUNC_RSVD_7;
        return w;
    endfunction

    // Present one word, hold it until accepted, then record what it should give
    task automatic send_word(input cmd_word_t w, input bit typed, input res_word_t want);
        res_word_t r;
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        r = predict_offset_delay(w);
        snap_q.push_back(typed ? want : r);
        if (w.func == FUNC_SET_M2S || w.func == FUNC_SET_S2M || w.func == FUNC_SET_PEER)
            n_set++;
        else if (w.func == FUNC_CLR_M2S || w.func == FUNC_CLR_S2M || w.func == FUNC_CLR_PEER)
            n_clear++;
        else
            n_ignored++;
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (snap_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (snap_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("ERROR: unexpected result word %h at %0t", res, $realtime);
            end
            else
            begin
                want = snap_q.pop_front();
                n_checked++;
                if (want.complete)
                    n_complete++;
                if (res.complete !== want.complete
                    || res.mean_delay !== want.mean_delay
                    || res.master_offset !== want.master_offset
                    || res.protocol_time !== want.protocol_time)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("ERROR: result %0d at %0t", n_checked, $realtime);
                        $display("  complete exp %0b got %0b", want.complete, res.complete);
                        $display("  delay    exp %h got %h", want.mean_delay, res.mean_delay);
                        $display("  offset   exp %h got %h",
                                 want.master_offset, res.master_offset);
                        $display("  rx time  exp %h got %h",
                                 want.protocol_time, res.protocol_time);
                    end
                end
            end
        end
    end

    initial
    begin
        cmd_word_t w;
        int        sent;

        // Directed: empty state, unused codes, extremes, both modes, mode switches
        add_row(FUNC_CLR_M2S,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '{1'b0, 64'd0, 64'd0, 64'd0});
        add_row(FUNC_CLR_S2M,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '{1'b0, 64'd0, 64'd0, 64'd0});
        add_row(FUNC_CLR_PEER, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '{1'b0, 64'd0, 64'd0, 64'd0});
        add_row(FUNC_RSVD_6,   ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '{1'b0, 64'd0, 64'd0, 64'd0});
        add_row(FUNC_RSVD_7,   ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '{1'b0, 64'd0, 64'd0, 64'd0});
        // m2s alone is not enough data
        add_row(FUNC_SET_M2S,  64'd0, ALL_ONES, 64'd0, 64'd0, 64'd0,
                1'b1, '{1'b0, 64'd0, 64'd0, ALL_ONES});
        // m2s transit of minus one, s2m transit zero: delay -1, offset 0
        add_row(FUNC_SET_S2M,  64'd0, 64'd0, ALL_ONES, ALL_ONES, 64'd0,
                1'b1, '{1'b1, ALL_ONES, 64'd0, 64'd0});
        add_row(FUNC_CLR_S2M,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                1'b1, '{1'b0, ALL_ONES, 64'd0, 64'd0});
        add_row(FUNC_SET_M2S,  64'd0, ALL_ONES, ALL_ONES, ALL_ONES, S64_MAX,
                1'b1, '{1'b0, ALL_ONES, 64'd0, ALL_ONES});
        add_row(FUNC_SET_S2M,  ALL_ONES, ALL_ONES, 64'd0, 64'd0, S64_MIN);
        add_row(FUNC_SET_PEER, 64'd0, ALL_ONES, 64'd0, ALL_ONES, S64_MIN);
        add_row(FUNC_SET_S2M,  S64_MIN, S64_MAX, 64'd0, 64'd0, ALL_ONES);
        add_row(FUNC_RSVD_7,   rand64(), rand64(), rand64(), rand64(), rand64());
        add_row(FUNC_CLR_PEER, rand64(), rand64(), rand64(), rand64(), rand64());
        add_row(FUNC_SET_PEER, 64'd3, 64'd0, 64'd5, 64'd1, S64_MAX);
        add_row(FUNC_CLR_M2S,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        add_row(FUNC_SET_PEER, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        // peer mode, then an odd negative end-to-end sum that must round down
        add_row(FUNC_SET_M2S,  64'd3, 64'd0, 64'd0, 64'd0, 64'd0);
        add_row(FUNC_SET_S2M,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        add_row(FUNC_CLR_S2M,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        add_row(FUNC_SET_M2S,  rand64(), rand64(), rand64(), rand64(), rand_corr());
        add_row(FUNC_CLR_M2S,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        // Random events, one idling pattern per phase
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            idle_pct  = IDLE_BY_PHASE[ph];
            stall_pct = STALL_BY_PHASE[ph];
            sent      = 0;
            while (sent < N_EVENTS / N_PHASES)
            begin
                sender_gap();
                w = rand_event();
                send_word(w, 1'b0, '0);
                if (w.func != FUNC_RSVD_6 && w.func != FUNC_RSVD_7)
                    sent++;
            end
            // hold the sender until every result is back
            wait_drained();
        end

        stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Sent %0d set, %0d clear and %0d unused-code words over %0d phases;",
                 n_set, n_clear, n_ignored, N_PHASES);
        $display("compared %0d results, %0d with a fresh delay and offset.",
                 n_checked, n_complete);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
